[rtl/rmsp_pkg.sv]
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared types and constants for the RMSprop parameter update block.
// ----------------------------------------------------------------------------
package rmsp_pkg;

	localparam int IDX_W    = 12;
	localparam int DEPTH    = 4096;
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int VAL_W    = 32;
	localparam int RATE_W   = 24;
	localparam int DECAY_W  = 16;
	localparam int ADDR_W   = 4;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LRATE  = 2'd1;
	localparam logic [1:0] REG_DECAY  = 2'd2;

	localparam logic [RATE_W-1:0]  LRATE_RST = 24'd16777;
	localparam logic [DECAY_W-1:0] DECAY_RST = 16'd58982;
	localparam logic [32:0]        EPS_Q24   = 33'd17;

	typedef struct packed {
		logic [IDX_W-1:0]        element_index;
		logic signed [VAL_W-1:0] gradient;
		logic signed [VAL_W-1:0] param_value;
		logic                    own_rate_valid;
		logic [RATE_W-1:0]       own_rate;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic signed [VAL_W-1:0] new_param_value;
		logic [VAL_W-1:0]        new_mean_square;
		logic                    saturated;
	} out_t;

endpackage

[rtl/rmsprop_param_update.sv]
// ----------------------------------------------------------------------------
// rmsprop_param_update
// RMSprop update of one parameter per beat with a per-index mean-square store.
// ----------------------------------------------------------------------------
// Takes one beat per cycle, while the output buffer has room, once the store
// clear after reset has finished (in_ready low meanwhile). Three stages read
// and update the mean square in the store; a 29-stage square-root pipeline
// and a 56-stage restoring divider follow. Back-to-back beats to the same
// index are forwarded around the store's read-modify-write loop. A two-entry
// output buffer absorbs output stalls; the whole pipeline holds while that
// buffer is full.
module rmsprop_param_update
	import rmsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SQ_N = 29;
	localparam int DV_N = 56;

	typedef struct packed {
		logic              v;
		logic [IDX_W-1:0]  idx;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       p;
		logic              neg;
		logic [31:0]       mag;
		logic [23:0]       rate;
	} s1_t;

	typedef struct packed {
		logic              v;
		logic [IDX_W-1:0]  idx;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       p;
		logic              neg;
		logic [38:0]       gsq;
		logic [55:0]       n;
		logic [31:0]       old;
	} s2_t;

	typedef struct packed {
		logic              v;
		logic [IDX_W-1:0]  idx;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       p;
		logic              neg;
		logic [55:0]       a;
		logic [55:0]       n;
		logic [31:0]       old;
	} s3_t;

	typedef struct packed {
		logic             v;
		logic [IDX_W-1:0] idx;
		logic [31:0]      p;
		logic             neg;
		logic             en;
		logic [31:0]      ms;
		logic             msat;
		logic [55:0]      nq;
		logic [31:0]      rem;
		logic [28:0]      root;
		logic [57:0]      x;
	} stg_t;

	function automatic stg_t sq_step(stg_t s);
		stg_t        r;
		logic [31:0] r2;
		logic [31:0] t;
		r  = s;
		r2 = {s.rem[29:0], s.x[57:56]};
		t  = {1'b0, s.root, 2'b01};
		if (r2 >= t) begin
			r.rem  = r2 - t;
			r.root = {s.root[27:0], 1'b1};
		end else begin
			r.rem  = r2;
			r.root = {s.root[27:0], 1'b0};
		end
		r.x = {s.x[55:0], 2'b00};
		return r;
	endfunction

	function automatic stg_t dv_step(stg_t s);
		stg_t        r;
		logic [29:0] r2;
		logic [29:0] d;
		r  = s;
		r2 = {s.rem[28:0], s.nq[55]};
		d  = {1'b0, s.root};
		if (r2 >= d) begin
			r.rem = {3'b000, 29'(r2 - d)};
			r.nq  = {s.nq[54:0], 1'b1};
		end else begin
			r.rem = {3'b000, r2[28:0]};
			r.nq  = {s.nq[54:0], 1'b0};
		end
		return r;
	endfunction

	logic              en_q;
	logic [23:0]       lrate_q;
	logic [15:0]       decay_q;
	logic [SLOT_W:0]   clr_q;
	logic              clearing;
	logic              adv;

	logic [31:0]       mem [DEPTH];
	logic [31:0]       rd_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;
	logic [31:0]       mem_wd;
	logic              wr_item;

	s1_t               s1_q;
	s2_t               s2_q;
	s3_t               s3_q;
	logic              byp_s1;
	logic [31:0]       bypd_s1;
	logic [31:0]       old1;
	logic [56:0]       ms_full;
	logic              ms_ovf;
	logic [31:0]       ms_new;
	stg_t              s4_q;
	stg_t              sq_init;
	stg_t              sq_d [SQ_N];
	stg_t              sq_q [SQ_N];
	stg_t              dv_init;
	stg_t              dv_d [DV_N];
	stg_t              dv_q [DV_N];

	logic signed [63:0] np;
	logic               np_ovf;
	out_t               fin;
	out_t               ent_q [2];
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			lrate_q <= LRATE_RST;
			decay_q <= DECAY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_ENABLE: en_q    <= pwdata[0];
				REG_LRATE:  lrate_q <= pwdata[23:0];
				REG_DECAY:  decay_q <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE: prdata = {31'd0, en_q};
			REG_LRATE:  prdata = {8'd0, lrate_q};
			REG_DECAY:  prdata = {16'd0, decay_q};
			default:    prdata = 32'd0;
		endcase
	end

	// store clear after reset
	assign clearing = !clr_q[SLOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign adv      = (cnt_q != 2'd2);
	assign in_ready = adv && !clearing;

	// mean-square store
	assign wr_item = adv && s3_q.v && en_q;
	assign mem_we  = clearing || wr_item;
	assign mem_wa  = clearing ? clr_q[SLOT_W-1:0] : s3_q.slot;
	assign mem_wd  = clearing ? 32'd0 : ms_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (adv) begin
			rd_q <= mem[in_data.element_index[SLOT_W-1:0]];
		end
	end

	// stage 1: capture, magnitude, rate select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q.v <= 1'b0;
		end else if (adv) begin
			s1_q.v    <= in_valid && in_ready;
			s1_q.idx  <= in_data.element_index;
			s1_q.slot <= in_data.element_index[SLOT_W-1:0];
			s1_q.p    <= in_data.param_value;
			s1_q.neg  <= in_data.gradient[31];
			s1_q.mag  <= in_data.gradient[31] ? 32'(-in_data.gradient) : in_data.gradient;
			s1_q.rate <= in_data.own_rate_valid ? in_data.own_rate : lrate_q;
			byp_s1    <= wr_item && (s3_q.slot == in_data.element_index[SLOT_W-1:0]);
			bypd_s1   <= ms_new;
		end
	end

	assign old1 = byp_s1 ? bypd_s1 : rd_q;

	// stage 2: gradient square and rate product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q.v <= 1'b0;
		end else if (adv) begin
			s2_q.v    <= s1_q.v;
			s2_q.idx  <= s1_q.idx;
			s2_q.slot <= s1_q.slot;
			s2_q.p    <= s1_q.p;
			s2_q.neg  <= s1_q.neg;
			s2_q.gsq  <= 39'((64'(s1_q.mag) * 64'(s1_q.mag)) >> 24);
			s2_q.n    <= 56'(s1_q.rate) * 56'(s1_q.mag);
			s2_q.old  <= (wr_item && s3_q.slot == s1_q.slot) ? ms_new : old1;
		end
	end

	// stage 3: weighted gradient term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_q.v <= 1'b0;
		end else if (adv) begin
			s3_q.v    <= s2_q.v;
			s3_q.idx  <= s2_q.idx;
			s3_q.slot <= s2_q.slot;
			s3_q.p    <= s2_q.p;
			s3_q.neg  <= s2_q.neg;
			s3_q.a    <= (56'd65536 - 56'(decay_q)) * 56'(s2_q.gsq);
			s3_q.n    <= s2_q.n;
			s3_q.old  <= (wr_item && s3_q.slot == s2_q.slot) ? ms_new : s2_q.old;
		end
	end

	// mean-square update, written back this cycle
	assign ms_full = {1'b0, s3_q.a} + 57'(48'(decay_q) * 48'(s3_q.old));
	assign ms_ovf  = |ms_full[56:48];
	assign ms_new  = !en_q ? s3_q.old : (ms_ovf ? 32'hFFFF_FFFF : ms_full[47:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_q.v <= 1'b0;
		end else if (adv) begin
			s4_q.v    <= s3_q.v;
			s4_q.idx  <= s3_q.idx;
			s4_q.p    <= s3_q.p;
			s4_q.neg  <= s3_q.neg;
			s4_q.en   <= en_q;
			s4_q.ms   <= ms_new;
			s4_q.msat <= en_q && ms_ovf;
			s4_q.nq   <= s3_q.n;
			s4_q.rem  <= '0;
			s4_q.root <= '0;
			s4_q.x    <= {1'b0, {1'b0, s4_q.ms} + EPS_Q24, 24'd0};
		end
	end

	// square root of (ms + eps) in Q.24
	always_comb begin
		sq_init   = s4_q;
		sq_init.x = {1'b0, {1'b0, s4_q.ms} + EPS_Q24, 24'd0};
		sq_d[0]   = sq_step(sq_init);
		for (int j = 1; j < SQ_N; j++) begin
			sq_d[j] = sq_step(sq_q[j-1]);
		end
	end

	for (genvar j = 0; j < SQ_N; j++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_q[j].v <= 1'b0;
			end else if (adv) begin
				sq_q[j] <= sq_d[j];
			end
		end
	end

	// step = rate * |g| / root
	always_comb begin
		dv_init     = sq_q[SQ_N-1];
		dv_init.rem = '0;
		dv_d[0]     = dv_step(dv_init);
		for (int j = 1; j < DV_N; j++) begin
			dv_d[j] = dv_step(dv_q[j-1]);
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[j].v <= 1'b0;
			end else if (adv) begin
				dv_q[j] <= dv_d[j];
			end
		end
	end

	// apply step and saturate
	always_comb begin
		np = dv_q[DV_N-1].neg
			? 64'(signed'(dv_q[DV_N-1].p)) + signed'({8'd0, dv_q[DV_N-1].nq})
			: 64'(signed'(dv_q[DV_N-1].p)) - signed'({8'd0, dv_q[DV_N-1].nq});
		np_ovf = !((&np[63:31]) || !(|np[63:31]));
		fin.out_index       = dv_q[DV_N-1].idx;
		fin.new_mean_square = dv_q[DV_N-1].ms;
		if (!dv_q[DV_N-1].en) begin
			fin.new_param_value = dv_q[DV_N-1].p;
			fin.saturated       = 1'b0;
		end else begin
			if (np_ovf) begin
				fin.new_param_value = np[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				fin.new_param_value = np[31:0];
			end
			fin.saturated = np_ovf || dv_q[DV_N-1].msat;
		end
	end

	// output buffer
	assign push      = adv && dv_q[DV_N-1].v;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[rp_q ^ cnt_q[0]] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
